>>> rtl/core/power_flow_jacobian_mismatch_macros.svh
// assertion macros shared by the jacobian and mismatch query unit
`ifndef POWER_FLOW_JACOBIAN_MISMATCH_MACROS_SVH
`define POWER_FLOW_JACOBIAN_MISMATCH_MACROS_SVH

// clocked check, quiet while reset is asserted
`define PFJM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define PFJM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/pfjm_pkg.sv
// shared types, codes and constants of the jacobian and mismatch query unit
package pfjm_pkg;

  localparam int MaxBusesDefault = 64;
  localparam int FracBitsDefault = 24;
  localparam int ApbAddrW = 4;

  localparam int CordicSteps = 30;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  // arctangent of 2^-i in Q30
  localparam logic [30:0] AtanQ30 [CordicSteps] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2};

  typedef enum logic [2:0] {
    OpWriteBus   = 3'd0,
    OpWriteAdm   = 3'd1,
    OpWriteOrder = 3'd2,
    OpJacobian   = 3'd3,
    OpMismatch   = 3'd4
  } pfjm_op_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusSat   = 2'd2
  } pfjm_status_e;

  typedef enum logic [1:0] {
    RegNumPq    = 2'd0,
    RegNumPv    = 2'd1,
    RegNumBuses = 2'd2
  } pfjm_reg_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         bus;
    logic [5:0]         other_bus;
    logic [5:0]         position;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] magnitude;
    logic signed [31:0] angle;
    logic signed [31:0] p_spec;
    logic signed [31:0] q_spec;
    logic signed [31:0] conductance;
    logic signed [31:0] susceptance;
  } pfjm_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } pfjm_out_t;

  typedef struct packed {
    logic [6:0] num_pq;
    logic [6:0] num_pv;
    logic [6:0] num_buses;
  } pfjm_cfg_t;

endpackage

>>> rtl/core/pfjm_ram.sv
// generic single-write single-read ram with registered read data
module pfjm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/pfjm_cordic.sv
// iterative angle reduction and cordic sine and cosine unit
module pfjm_cordic
  import pfjm_pkg::*;
#(
  parameter int FracBits = FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] diff_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int Shift = 30 - FracBits;
  localparam int RedSteps = 31 - FracBits;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PiW = (PiQ60 + (64'd1 << (59 - FracBits))) >> (60 - FracBits);
  localparam logic [63:0] TwoPiW = (PiQ60 + (64'd1 << (58 - FracBits))) >> (59 - FracBits);
  localparam logic [63:0] HalfPiW = (PiQ60 + (64'd1 << (60 - FracBits))) >> (61 - FracBits);
  localparam logic signed [33:0] Pi = 34'(PiW);
  localparam logic signed [33:0] TwoPi = 34'(TwoPiW);
  localparam logic signed [33:0] HalfPi = 34'(HalfPiW);
  localparam logic [39:0] TwoPi40 = 40'(TwoPiW);

  typedef enum logic [2:0] {CIdle, CReduce, CFold, CRotate, CFinish} state_e;

  state_e             state_q;
  logic [4:0]         cnt_q;
  logic [33:0]        rem_q;
  logic               dneg_q;
  logic               fneg_q;
  logic signed [33:0] x_q;
  logic signed [33:0] y_q;
  logic signed [33:0] z_q;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;
  logic               done_q;

  logic signed [33:0] d_ext;
  logic [33:0]        d_abs;
  logic [39:0]        tp_sh;
  logic               rem_ge;
  logic signed [33:0] r0;
  logic signed [33:0] r1;
  logic signed [33:0] r2;
  logic               fold_neg;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  // magnitude of the difference, reduction compare, folding and rotation terms
  always_comb begin
    d_ext = {diff_i[32], diff_i};
    d_abs = d_ext[33] ? 34'(-d_ext) : 34'(d_ext);
    tp_sh = TwoPi40 << cnt_q;
    rem_ge = {6'b0, rem_q} >= tp_sh;
    r0 = dneg_q ? -$signed(rem_q) : $signed(rem_q);
    if (r0 > Pi) begin
      r1 = r0 - TwoPi;
    end else if (r0 < -Pi) begin
      r1 = r0 + TwoPi;
    end else begin
      r1 = r0;
    end
    fold_neg = 1'b0;
    if (r1 > HalfPi) begin
      r2 = r1 - Pi;
      fold_neg = 1'b1;
    end else if (r1 < -HalfPi) begin
      r2 = r1 + Pi;
      fold_neg = 1'b1;
    end else begin
      r2 = r1;
    end
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = $signed({3'b0, AtanQ30[cnt_q]});
    xf = fneg_q ? -x_q : x_q;
    yf = fneg_q ? -y_q : y_q;
  end

  // sequencer: modulo by shift and subtract, fold, then one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      cnt_q   <= '0;
      rem_q   <= '0;
      dneg_q  <= 1'b0;
      fneg_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      sin_q   <= '0;
      cos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        CIdle: begin
          if (start_i) begin
            rem_q   <= d_abs;
            dneg_q  <= diff_i[32];
            cnt_q   <= 5'(RedSteps - 1);
            state_q <= CReduce;
          end
        end
        CReduce: begin
          if (rem_ge) begin
            rem_q <= rem_q - tp_sh[33:0];
          end
          if (cnt_q == '0) begin
            state_q <= CFold;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        CFold: begin
          z_q     <= r2 <<< Shift;
          x_q     <= CordicGainQ30;
          y_q     <= '0;
          fneg_q  <= fold_neg;
          cnt_q   <= '0;
          state_q <= CRotate;
        end
        CRotate: begin
          if (z_q >= 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end
          if (cnt_q == 5'(CordicSteps - 1)) begin
            state_q <= CFinish;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        CFinish: begin
          cos_q   <= 32'(xf >>> Shift);
          sin_q   <= 32'(yf >>> Shift);
          done_q  <= 1'b1;
          state_q <= CIdle;
        end
        default: state_q <= CIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

>>> rtl/core/pfjm_apb.sv
// configuration registers behind the apb port
module pfjm_apb
  import pfjm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pfjm_cfg_t           cfg_o
);

  pfjm_cfg_t cfg_q;
  pfjm_reg_e idx;
  logic      wr;

  assign idx = pfjm_reg_e'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_pq    <= 7'd0;
      cfg_q.num_pv    <= 7'd0;
      cfg_q.num_buses <= 7'd1;
    end else if (wr) begin
      case (idx)
        RegNumPq:    cfg_q.num_pq    <= pwdata[6:0];
        RegNumPv:    cfg_q.num_pv    <= pwdata[6:0];
        RegNumBuses: cfg_q.num_buses <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegNumPq:    prdata = {25'b0, cfg_q.num_pq};
      RegNumPv:    prdata = {25'b0, cfg_q.num_pv};
      RegNumBuses: prdata = {25'b0, cfg_q.num_buses};
      default:     prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

>>> rtl/core/power_flow_jacobian_mismatch.sv
// top level of the polar newton-raphson jacobian and mismatch query unit
//
// channel   direction  handshake                 payload
// item      in         start high, busy low      item_i (pfjm_in_t)
// result    out        result_valid_o strobe     result_o (pfjm_out_t)
// config    in         apb psel/penable/pwrite   paddr, pwdata, prdata
//
// store writes (bus, admittance, ordering) keep busy low and can come back to back
// an out-of-range query answers in the cycle after it is taken, busy stays low
// a query otherwise holds busy high over its terms: one for an off-diagonal entry, nb
// for a diagonal or a mismatch entry, nb = min(num_buses, MaxBuses); a term is the cordic
// unit (31 - FracBits reduction steps, fold, 30 rotations, finish) plus load/mul steps
// reset clears control only; the one-cycle strobe comes as busy falls and cannot stall
`include "power_flow_jacobian_mismatch_macros.svh"

module power_flow_jacobian_mismatch
  import pfjm_pkg::*;
#(
  parameter int MaxBuses = MaxBusesDefault,
  parameter int FracBits = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pfjm_in_t            item_i,
  output logic                busy,
  output logic                result_valid_o,
  output pfjm_out_t           result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int BW = $clog2(MaxBuses);
  localparam int AdAW = $clog2(MaxBuses * MaxBuses);
  localparam int CW = $clog2(MaxBuses + 1);
  localparam int AccW = 32 + CW + 1;

  typedef enum logic [3:0] {
    SIdle, SOrdK, SOrdJ, SRdK, SLdK, SLdJ, SCord,
    SM1, SM2, SAdd, SM3, SFin, SS1, SS2, SOut
  } state_e;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } fx_t;

  // saturate a wide value to 32 bits
  function automatic fx_t sat32(input logic signed [63:0] v);
    fx_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.v   = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.v   = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.v   = 32'(v);
    end
    return r;
  endfunction

  // fixed point product with floor rounding and saturation
  function automatic fx_t fmul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return sat32(p >>> FracBits);
  endfunction

  pfjm_cfg_t cfg;

  state_e state_q;
  state_e state_d;
  logic   result_valid_q;
  logic   result_valid_d;

  // payload registers
  logic               kind_q;
  logic               sum_q;
  logic               mism_q;
  logic               sxneg_q;
  logic               syneg_q;
  logic [BW-1:0]      cb_q;
  logic [5:0]         k_q;
  logic [5:0]         j_q;
  logic               jv_q;
  logic signed [31:0] mag_k_q;
  logic signed [31:0] ang_k_q;
  logic signed [31:0] y_q;
  logic signed [31:0] mag_j_q;
  logic signed [31:0] g_q;
  logic signed [31:0] b_q;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;
  logic signed [31:0] p1_q;
  logic signed [31:0] p2_q;
  logic signed [31:0] inner_q;
  logic signed [AccW-1:0] acc_q;
  logic [CW-1:0]      cnt_q;
  logic signed [31:0] x_q;
  logic               sat_q;
  pfjm_out_t          result_q;

  // decode of the incoming item
  logic          accept;
  logic          is_jac;
  logic          is_mis;
  logic [7:0]    npqpv;
  logic [8:0]    n_all;
  logic          top;
  logic          left;
  logic [7:0]    ra;
  logic [7:0]    cb;
  logic          dg;
  logic          oob;

  // memory ports
  logic [5:0]    order_rdata;
  logic [BW-1:0] order_raddr;
  logic [127:0]  bus_rdata;
  logic [BW-1:0] bus_raddr;
  logic [63:0]   adm_rdata;
  logic [AdAW-1:0] adm_raddr;
  logic          order_we;
  logic          bus_we;
  logic          adm_we;

  // loop control and arithmetic
  logic          kv;
  logic          jv_now;
  logic [CW-1:0] nb;
  logic          more_terms;
  logic signed [31:0] rd_mag;
  logic signed [31:0] rd_ang;
  logic signed [31:0] rd_p;
  logic signed [31:0] rd_q;
  logic signed [31:0] rd_g;
  logic signed [31:0] rd_b;
  logic signed [31:0] ang_j;
  logic signed [32:0] ang_diff;
  logic          cord_done;
  logic signed [31:0] cord_sin;
  logic signed [31:0] cord_cos;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  fx_t           mul_r;
  fx_t           acc_sat;
  fx_t           add_r;
  fx_t           out_r;
  logic signed [63:0] add_s;
  logic signed [63:0] out_x;
  logic signed [63:0] out_y;
  logic          range_hit;

  pfjm_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item decode: block position of row and column, range checks
  always_comb begin
    accept = start && !busy;
    is_jac = item_i.op == OpJacobian;
    is_mis = item_i.op == OpMismatch;
    npqpv  = {1'b0, cfg.num_pq} + {1'b0, cfg.num_pv};
    n_all  = {1'b0, npqpv} + {2'b0, cfg.num_pq};
    top    = {1'b0, item_i.row} < npqpv;
    left   = {1'b0, item_i.col} < npqpv;
    ra     = top ? {1'b0, item_i.row} : {1'b0, item_i.row} - npqpv;
    cb     = left ? {1'b0, item_i.col} : {1'b0, item_i.col} - npqpv;
    dg     = is_jac && (ra == cb);
    if (is_jac) begin
      oob = ({2'b0, item_i.row} >= n_all) || ({2'b0, item_i.col} >= n_all) ||
            (int'(ra) >= MaxBuses) || (int'(cb) >= MaxBuses);
    end else begin
      oob = ({2'b0, item_i.row} >= n_all) || (int'(ra) >= MaxBuses);
    end
  end

  // store writes
  assign order_we = accept && (item_i.op == OpWriteOrder) && (int'(item_i.position) < MaxBuses);
  assign bus_we   = accept && (item_i.op == OpWriteBus) && (int'(item_i.bus) < MaxBuses);
  assign adm_we   = accept && (item_i.op == OpWriteAdm) && (int'(item_i.bus) < MaxBuses) &&
                    (int'(item_i.other_bus) < MaxBuses);

  // read addresses: ordering slot, then bus k, then the bus of each term
  always_comb begin
    kv     = int'(k_q) < MaxBuses;
    jv_now = int'(j_q) < MaxBuses;
    nb     = (int'(cfg.num_buses) < MaxBuses) ? CW'(cfg.num_buses) : CW'(MaxBuses);
    more_terms = ({1'b0, cnt_q} + 1'b1) < {1'b0, nb};
    order_raddr = (state_q == SIdle) ? BW'(ra) : cb_q;
    case (state_q)
      SLdK:    bus_raddr = sum_q ? '0 : BW'(j_q);
      SM3:     bus_raddr = BW'(cnt_q + 1'b1);
      default: bus_raddr = BW'(k_q);
    endcase
    adm_raddr = AdAW'(int'(BW'(k_q)) * MaxBuses + int'(bus_raddr));
  end

  pfjm_ram #(.Width(6), .Depth(MaxBuses)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (order_we),
    .waddr_i (BW'(item_i.position)),
    .wdata_i (item_i.bus),
    .raddr_i (order_raddr),
    .rdata_o (order_rdata)
  );

  pfjm_ram #(.Width(128), .Depth(MaxBuses)) u_bus_ram (
    .clk_i   (clk_i),
    .we_i    (bus_we),
    .waddr_i (BW'(item_i.bus)),
    .wdata_i ({item_i.magnitude, item_i.angle, item_i.p_spec, item_i.q_spec}),
    .raddr_i (bus_raddr),
    .rdata_o (bus_rdata)
  );

  pfjm_ram #(.Width(64), .Depth(MaxBuses * MaxBuses)) u_adm_ram (
    .clk_i   (clk_i),
    .we_i    (adm_we),
    .waddr_i (AdAW'(int'(item_i.bus) * MaxBuses + int'(item_i.other_bus))),
    .wdata_i ({item_i.conductance, item_i.susceptance}),
    .raddr_i (adm_raddr),
    .rdata_o (adm_rdata)
  );

  // unpack read data; an out-of-range term bus reads as zero
  always_comb begin
    rd_mag   = $signed(bus_rdata[127:96]);
    rd_ang   = $signed(bus_rdata[95:64]);
    rd_p     = $signed(bus_rdata[63:32]);
    rd_q     = $signed(bus_rdata[31:0]);
    rd_g     = $signed(adm_rdata[63:32]);
    rd_b     = $signed(adm_rdata[31:0]);
    ang_j    = jv_q ? rd_ang : '0;
    ang_diff = {ang_k_q[31], ang_k_q} - {ang_j[31], ang_j};
  end

  pfjm_cordic #(.FracBits(FracBits)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == SLdJ),
    .diff_i  (ang_diff),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  // shared multiplier operand select
  always_comb begin
    acc_sat = sat32({{(64 - AccW){acc_q[AccW-1]}}, acc_q});
    case (state_q)
      SM1: begin
        mul_a = g_q;
        mul_b = kind_q ? cos_q : sin_q;
      end
      SM2: begin
        mul_a = b_q;
        mul_b = kind_q ? sin_q : cos_q;
      end
      SM3: begin
        mul_a = mag_j_q;
        mul_b = inner_q;
      end
      SFin: begin
        mul_a = mag_k_q;
        mul_b = acc_sat.v;
      end
      SS1: begin
        mul_a = y_q;
        mul_b = mag_k_q;
      end
      SS2: begin
        mul_a = p1_q;
        mul_b = mag_k_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_r = fmul(mul_a, mul_b);
    add_s = kind_q ? $signed({{32{p1_q[31]}}, p1_q}) + $signed({{32{p2_q[31]}}, p2_q})
                   : $signed({{32{p1_q[31]}}, p1_q}) - $signed({{32{p2_q[31]}}, p2_q});
    add_r = sat32(add_s);
    out_x = $signed({{32{x_q[31]}}, x_q});
    out_y = $signed({{32{y_q[31]}}, y_q});
    out_r = sat32((sxneg_q ? -out_x : out_x) + (syneg_q ? -out_y : out_y));
  end

  // query sequencer next state
  always_comb begin
    state_d = state_q;
    result_valid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (accept && (is_jac || is_mis)) begin
          if (oob) begin
            result_valid_d = 1'b1;
          end else begin
            state_d = SOrdK;
          end
        end
      end
      SOrdK: state_d = sum_q ? SRdK : SOrdJ;
      SOrdJ: state_d = SRdK;
      SRdK:  state_d = SLdK;
      SLdK:  state_d = (sum_q && (nb == '0)) ? SFin : SLdJ;
      SLdJ:  state_d = SCord;
      SCord: begin
        if (cord_done) begin
          state_d = SM1;
        end
      end
      SM1:  state_d = SM2;
      SM2:  state_d = SAdd;
      SAdd: state_d = SM3;
      SM3:  state_d = (sum_q && more_terms) ? SLdJ : SFin;
      SFin: state_d = (sum_q && !mism_q) ? SS1 : SOut;
      SS1:  state_d = SS2;
      SS2:  state_d = SOut;
      SOut: begin
        state_d = SIdle;
        result_valid_d = 1'b1;
      end
      default: state_d = SIdle;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (accept && (is_jac || is_mis)) begin
          kind_q  <= is_jac ? (top ^ left) : top;
          sum_q   <= is_mis || dg;
          mism_q  <= is_mis;
          sxneg_q <= is_mis || (is_jac && ((top && left && dg) || (!top && left && !dg)));
          syneg_q <= dg && !(top && !left);
          cb_q    <= BW'(cb);
          sat_q   <= 1'b0;
          if (oob) begin
            result_q.value  <= '0;
            result_q.status <= StatusRange;
          end
        end
      end
      SOrdK: k_q <= order_rdata;
      SOrdJ: j_q <= order_rdata;
      SLdK: begin
        mag_k_q <= kv ? rd_mag : '0;
        ang_k_q <= kv ? rd_ang : '0;
        if (!kv || !sum_q) begin
          y_q <= '0;
        end else if (mism_q) begin
          y_q <= kind_q ? rd_p : rd_q;
        end else begin
          y_q <= kind_q ? rd_g : rd_b;
        end
        jv_q  <= sum_q || jv_now;
        cnt_q <= '0;
        acc_q <= '0;
      end
      SLdJ: begin
        mag_j_q <= jv_q ? rd_mag : '0;
        g_q     <= (jv_q && kv) ? rd_g : '0;
        b_q     <= (jv_q && kv) ? rd_b : '0;
      end
      SCord: begin
        if (cord_done) begin
          sin_q <= cord_sin;
          cos_q <= cord_cos;
        end
      end
      SM1: begin
        p1_q  <= mul_r.v;
        sat_q <= sat_q | mul_r.sat;
      end
      SM2: begin
        p2_q  <= mul_r.v;
        sat_q <= sat_q | mul_r.sat;
      end
      SAdd: begin
        inner_q <= add_r.v;
        sat_q   <= sat_q | add_r.sat;
      end
      SM3: begin
        acc_q <= acc_q + AccW'(mul_r.v);
        cnt_q <= cnt_q + 1'b1;
        sat_q <= sat_q | mul_r.sat;
      end
      SFin: begin
        x_q   <= mul_r.v;
        sat_q <= sat_q | mul_r.sat | acc_sat.sat;
      end
      SS1: begin
        p1_q  <= mul_r.v;
        sat_q <= sat_q | mul_r.sat;
      end
      SS2: begin
        y_q   <= mul_r.v;
        sat_q <= sat_q | mul_r.sat;
      end
      SOut: begin
        result_q.value  <= out_r.v;
        result_q.status <= (sat_q || out_r.sat) ? StatusSat : StatusOk;
      end
      default: ;
    endcase
  end

  assign busy           = state_q != SIdle;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;
  assign range_hit      = result_valid_o && (result_o.status == StatusRange);

  // checks on sequencing and results
  `PFJM_ASSERT(a_no_result_while_busy, busy |-> !result_valid_o, "result strobe while busy")
  `PFJM_ASSERT(a_range_gives_zero, range_hit |-> (result_o.value == '0), "range error nonzero")
  `PFJM_ASSERT(a_busy_needs_start, $rose(busy) |-> $past(start), "busy rose without a start")
  `PFJM_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> (!busy && !result_valid_o), "busy in reset")

endmodule
